// File: hw/rtl/upf_pkg.sv
package upf_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_RESULTS = 3;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h66;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;

    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_PERCENT = 2'd1;
    localparam logic [1:0] MODE_DIGIT   = 2'd2;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] data;
        logic [1:0]                  cnt;
        logic                        last;
    } t_bundle;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
               (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CH_0 && c <= CH_9) begin
            v = c - CH_0;
        end else if (c >= CH_LA && c <= CH_LF) begin
            v = c - CH_LA + 8'd10;
        end else if (c >= CH_UA && c <= CH_UF) begin
            v = c - CH_UA + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

// File: hw/rtl/upf_front.sv
module upf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_in_byte,
    input  logic            i_in_last,
    input  logic            i_full,
    output logic            o_push,
    output upf_pkg::t_bundle o_bundle
);
    import upf_pkg::*;

    logic [1:0] r_mode, n_mode;
    logic [7:0] r_held, n_held;
    logic [3:0][7:0] v;
    logic [2:0] n;
    logic plain;
    logic accept;

    assign accept = i_valid && !i_full;

    always_comb begin
        v = '0;
        n = 3'd0;
        plain = 1'b0;
        n_mode = r_mode;
        n_held = r_held;
        if (n_mode == 2'd3) begin
            n_mode = MODE_NONE;
        end
        if (n_mode == MODE_DIGIT) begin
            if (is_hex(i_in_byte)) begin
                v[n[1:0]] = {hex_val(r_held), hex_val(i_in_byte)};
                n = n + 3'd1;
            end else begin
                v[n[1:0]] = CH_PERCENT;
                n = n + 3'd1;
                v[n[1:0]] = r_held;
                n = n + 3'd1;
                plain = 1'b1;
            end
            n_mode = MODE_NONE;
            n_held = 8'd0;
        end else if (n_mode == MODE_PERCENT) begin
            if (is_hex(i_in_byte)) begin
                n_held = i_in_byte;
                n_mode = MODE_DIGIT;
            end else begin
                v[n[1:0]] = CH_PERCENT;
                n = n + 3'd1;
                n_mode = MODE_NONE;
                plain = 1'b1;
            end
        end else begin
            plain = 1'b1;
        end
        if (plain) begin
            if (i_in_byte == CH_PERCENT) begin
                n_mode = MODE_PERCENT;
            end else if (i_in_byte == CH_PLUS) begin
                v[n[1:0]] = CH_SPACE;
                n = n + 3'd1;
            end else begin
                v[n[1:0]] = i_in_byte;
                n = n + 3'd1;
            end
        end
        if (i_in_last) begin
            if (n_mode != MODE_NONE) begin
                v[n[1:0]] = CH_PERCENT;
                n = n + 3'd1;
            end
            if (n_mode == MODE_DIGIT) begin
                v[n[1:0]] = n_held;
                n = n + 3'd1;
            end
            n_mode = MODE_NONE;
            n_held = 8'd0;
        end
    end

    assign o_bundle.data = v[MAX_RESULTS-1:0];
    assign o_bundle.cnt  = n[1:0];
    assign o_bundle.last = i_in_last;
    assign o_push        = accept && (n != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
            r_held <= 8'd0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_held <= n_held;
        end
    end

endmodule

// File: hw/rtl/upf_queue.sv
module upf_queue #(
    parameter int DEPTH = upf_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  upf_pkg::t_bundle i_bundle,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output upf_pkg::t_bundle o_bundle
);
    import upf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_bundle r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic do_push, do_pop;

    assign o_full   = (r_count == FULL_CNT);
    assign o_valid  = (r_count != '0);
    assign o_bundle = r_mem[r_rd];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/upf_back.sv
module upf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  upf_pkg::t_bundle i_bundle,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last
);
    import upf_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load, final_one;

    assign load      = i_q_valid && (!r_valid || !i_stall);
    assign final_one = (r_idx == i_bundle.cnt - 2'd1);
    assign o_pop     = load && final_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= final_one ? 2'd0 : r_idx + 2'd1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_bundle.data[r_idx];
            r_last <= i_bundle.last && final_one;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_out_last = r_last;

endmodule

// File: hw/rtl/url_percent_decoder_top.sv
// URL form percent decoder. Takes one encoded byte per transaction with a
// last-of-string flag and returns decoded bytes: a percent sign with two hex
// digits becomes one byte, a plus becomes a space, broken escapes come out
// literally and a pending escape is flushed at the end of the string. Input
// bytes are accepted one per cycle while the queue is not full; each is
// classified at once and its results, up to three, are queued as a bundle in
// a QUEUE_DEPTH entry queue. The output register drains one result byte per
// cycle while i_stall is low, and o_stall rises only once the queue is full.
// An accepted byte's first result passes through the queue, then the output register.
module url_percent_decoder_top #(
    parameter int QUEUE_DEPTH = upf_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);
    import upf_pkg::*;

    t_bundle f_bundle, q_bundle;
    logic    f_push, q_full, q_valid, b_pop;

    upf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .i_full    (q_full),
        .o_push    (f_push),
        .o_bundle  (f_bundle)
    );

    upf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_push),
        .i_bundle (f_bundle),
        .i_pop    (b_pop),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_bundle (q_bundle)
    );

    upf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_bundle   (q_bundle),
        .o_pop      (b_pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

    assign o_stall = q_full;

endmodule

// File: hw/rtl/upf_checker.sv
module upf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_out_last
);

    logic r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_seen <= 1'b1;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs not idle after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_out_last))
        else $error("stalled output transaction changed");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_seen)
        else $error("output transaction without any input transaction");

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while output side is empty");

endmodule

bind url_percent_decoder_top upf_checker u_upf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_out_byte (o_out_byte),
    .o_out_last (o_out_last)
);

// File: bench/tb_url_percent_decoder_top.sv
module tb_url_percent_decoder_top;
    import upf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 200;
    localparam int CALM_TAIL    = 30;
    localparam int SETTLE       = 10;

    typedef struct {
        logic [7:0] code;
        logic       fin;
        logic       drain;
    } t_enc_item;

    typedef struct {
        logic [7:0] code;
        logic       fin;
    } t_dec_item;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_in_byte;
    logic       i_in_last;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    t_enc_item  encoded_q[$];
    t_dec_item  decoded_q[$];
    t_enc_item  nxt;
    t_dec_item  want;

    logic [1:0] dec_mode;
    logic [7:0] dec_held;

    bit in_taken;
    bit calm;
    int calm_at;
    int gap_left;
    int stall_left;
    int errors;
    int cycles;
    int bytes_in;
    int bytes_out;
    int strings_done;
    int random_start;

    url_percent_decoder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) begin
            return int'(c) - int'(CH_0);
        end
        if (c >= CH_LA && c <= CH_LF) begin
            return int'(c) - int'(CH_LA) + 10;
        end
        if (c >= CH_UA && c <= CH_UF) begin
            return int'(c) - int'(CH_UA) + 10;
        end
        return -1;
    endfunction

    function automatic void queue_decoded(input logic [7:0] c);
        t_dec_item d;
        d.code = c;
        d.fin  = 1'b0;
        decoded_q.push_back(d);
    endfunction

    // advances the decoder state by one encoded byte and queues what it yields
    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        logic [1:0] st;
        logic       plain;
        int         lo;
        int         hi;
        int         n;
        logic [7:0] v;
        st    = (dec_mode == 2'd3) ? MODE_NONE : dec_mode;
        plain = 1'b0;
        n     = 0;
        lo    = hex_digit(b);
        if (st == MODE_DIGIT) begin
            if (lo >= 0) begin
                hi = hex_digit(dec_held);
                if (hi < 0) begin
                    hi = 0;
                end
                v = {hi[3:0], lo[3:0]};
                queue_decoded(v);
                n++;
            end else begin
                queue_decoded(CH_PERCENT);
                queue_decoded(dec_held);
                n += 2;
                plain = 1'b1;
            end
            st       = MODE_NONE;
            dec_held = 8'd0;
        end else if (st == MODE_PERCENT) begin
            if (lo >= 0) begin
                dec_held = b;
                st       = MODE_DIGIT;
            end else begin
                queue_decoded(CH_PERCENT);
                n++;
                st    = MODE_NONE;
                plain = 1'b1;
            end
        end else begin
            plain = 1'b1;
        end
        if (plain) begin
            if (b == CH_PERCENT) begin
                st = MODE_PERCENT;
            end else if (b == CH_PLUS) begin
                queue_decoded(CH_SPACE);
                n++;
            end else begin
                queue_decoded(b);
                n++;
            end
        end
        if (fin) begin
            if (st != MODE_NONE) begin
                queue_decoded(CH_PERCENT);
                n++;
            end
            if (st == MODE_DIGIT) begin
                queue_decoded(dec_held);
                n++;
            end
            st       = MODE_NONE;
            dec_held = 8'd0;
            if (n > 0) begin
                decoded_q[decoded_q.size() - 1].fin = 1'b1;
            end
        end
        dec_mode = st;
    endfunction

    task automatic push_byte(input logic [7:0] c, input logic fin);
        t_enc_item e;
        e.code  = c;
        e.fin   = fin;
        e.drain = 1'b0;
        encoded_q.push_back(e);
    endtask

    task automatic push_str(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i], fin && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] pick_hex();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10) begin
            return CH_0 + k[7:0];
        end else if (k < 16) begin
            return CH_LA + k[7:0] - 8'd10;
        end
        return CH_UA + k[7:0] - 8'd16;
    endfunction

    function automatic logic [7:0] pick_nonhex();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (hex_digit(c) >= 0) begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // a string of escapes, pluses, plain bytes, broken escapes; or raw bytes
    task automatic push_random_string();
        int         toks;
        int         kind;
        int         start;
        t_enc_item  e;
        toks  = $urandom_range(1, 10);
        start = encoded_q.size();
        if ($urandom_range(0, 9) == 0) begin
            for (int i = 0; i < toks; i++) begin
                e.code  = 8'($urandom_range(0, 255));
                e.fin   = 1'($urandom_range(0, 1));
                e.drain = 1'b0;
                encoded_q.push_back(e);
            end
            return;
        end
        for (int i = 0; i < toks; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                push_byte(CH_PERCENT, 1'b0);
                push_byte(pick_hex(), 1'b0);
                push_byte(pick_hex(), 1'b0);
            end else if (kind < 50) begin
                push_byte(CH_PLUS, 1'b0);
            end else if (kind < 70) begin
                push_byte(8'($urandom_range(8'h20, 8'h7e)), 1'b0);
            end else if (kind < 80) begin
                push_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (kind < 90) begin
                push_byte(CH_PERCENT, 1'b0);
                if ($urandom_range(0, 1)) begin
                    push_byte(pick_hex(), 1'b0);
                end
                push_byte(pick_nonhex(), 1'b0);
            end else begin
                push_byte(CH_PERCENT, 1'b0);
                if ($urandom_range(0, 1)) begin
                    push_byte(pick_hex(), 1'b0);
                end
            end
        end
        encoded_q[encoded_q.size() - 1].fin = 1'b1;
    endtask

    // monitor: accepts input transactions into the predictor, checks outputs
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n) begin
            in_taken = i_valid && !o_stall;
            if (in_taken) begin
                decode_byte(i_in_byte, i_in_last);
                bytes_in++;
                if (i_in_last) begin
                    strings_done++;
                end
            end
            if (o_valid && !i_stall) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected output transaction, byte %02h last %0b",
                             $time, o_out_byte, o_out_last);
                    errors++;
                end else begin
                    want = decoded_q.pop_front();
                    if (o_out_byte !== want.code) begin
                        $display("%0t: out_byte mismatch, expected %02h actual %02h",
                                 $time, want.code, o_out_byte);
                        errors++;
                    end
                    if (o_out_last !== want.fin) begin
                        $display("%0t: out_last mismatch, expected %0b actual %0b",
                                 $time, want.fin, o_out_last);
                        errors++;
                    end
                    bytes_out++;
                end
            end
            calm = (bytes_in >= calm_at);
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // driver for the encoded byte side
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (encoded_q.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (encoded_q[0].drain && decoded_q.size() != 0) begin
                    i_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(1, 13) - 1;
                    i_valid <= 1'b0;
                end else begin
                    nxt = encoded_q.pop_front();
                    i_in_byte <= nxt.code;
                    i_in_last <= nxt.fin;
                    i_valid   <= 1'b1;
                end
            end
        end
    end

    // back-pressure on the decoded byte side
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        i_clk     = 1'b0;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_stall   = 1'b0;
        i_in_byte = 8'd0;
        i_in_last = 1'b0;
        dec_mode  = MODE_NONE;
        dec_held  = 8'd0;
        calm_at   = 1 << 30;

        // directed strings
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b1);
        push_str("%fA", 1'b0);
        push_str("%90", 1'b0);
        push_str("%aF", 1'b1);
        push_str("+", 1'b0);
        push_str("%z", 1'b0);
        push_str("%4z", 1'b1);
        push_str("%%4", 1'b1);
        push_str("%4%", 1'b1);
        push_str("%+", 1'b0);
        push_str("%", 1'b1);

        random_start = encoded_q.size();
        while (encoded_q.size() < random_start + RANDOM_BYTES) begin
            push_random_string();
        end
        encoded_q[random_start].drain = 1'b1;
        encoded_q[random_start + RANDOM_BYTES / 2].drain = 1'b1;
        calm_at = encoded_q.size() - CALM_TAIL;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (encoded_q.size() != 0 || i_valid || decoded_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);

        $display("%0d encoded bytes in %0d strings, %0d decoded bytes checked",
                 bytes_in, strings_done, bytes_out);
        $display("escapes, pluses, broken escapes and end-of-string flushes under back-pressure");
        if (errors == 0 && decoded_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
